// File: hw/rtl/tensor_face_dof_index_generator_defines.svh
// Assertion macros used by the face index generator controller
`ifndef TENSOR_FACE_DOF_INDEX_GENERATOR_DEFINES_SVH
`define TENSOR_FACE_DOF_INDEX_GENERATOR_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, held off during reset
`define TFDIG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tfdig: same-cycle check failed");
// next-cycle implication, held off during reset
`define TFDIG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tfdig: next-cycle check failed");
`else
`define TFDIG_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TFDIG_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/tfdig_pkg.sv
// Shared types, constants and face tables of the face index generator
package tfdig_pkg;

  localparam int IDX_W         = 9;
  localparam int DIM_W         = 2;
  localparam int ORDER_W       = 3;
  localparam int FACE_W        = 3;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;
  localparam int DEF_MAX_ORDER = 7;

  localparam logic [DIM_W-1:0]   DIM_RESET   = 2'd3;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd1;

  // register index codes (word address bit)
  localparam logic REG_SPACE_DIM  = 1'b0;
  localparam logic REG_POLY_ORDER = 1'b1;

  // axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // 3D face table; the two top entries are never used
  localparam logic [1:0] NORMAL3D [8] = '{AXIS_Z, AXIS_Y, AXIS_X, AXIS_Y,
                                          AXIS_X, AXIS_Z, AXIS_X, AXIS_X};
  localparam logic       LEVEL3D  [8] = '{1'b0, 1'b0, 1'b1, 1'b1,
                                          1'b0, 1'b1, 1'b0, 1'b0};

  typedef struct packed {
    logic       bad;
    logic [1:0] normal;
    logic       level;
    logic [1:0] nfa;
  } face_geom_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic geom;
    logic init;
    logic step;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } dp_status_t;

  // validity, normal axis, level and face axis count for a face
  function automatic face_geom_t face_geom(input logic [DIM_W-1:0] dim,
                                           input logic [FACE_W-1:0] face);
    face_geom_t g;
    g = '0;
    case (dim)
      2'd1: begin
        g.bad    = (face > 3'd1);
        g.normal = AXIS_X;
        g.level  = face[0];
        g.nfa    = 2'd0;
      end
      2'd2: begin
        g.bad    = (face > 3'd3);
        g.normal = (face == 3'd0 || face == 3'd2) ? AXIS_Y : AXIS_X;
        g.level  = (face == 3'd1 || face == 3'd2);
        g.nfa    = 2'd1;
      end
      2'd3: begin
        g.bad    = (face > 3'd5);
        g.normal = NORMAL3D[face];
        g.level  = LEVEL3D[face];
        g.nfa    = 2'd2;
      end
      default: begin
        g.bad = 1'b1;
      end
    endcase
    return g;
  endfunction

endpackage

// File: hw/rtl/tfdig_face_if.sv
// Request channel: one face number per item
interface tfdig_face_if import tfdig_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FACE_W-1:0] face_number;

  modport source (output valid, output face_number, input ready);
  modport sink   (input valid, input face_number, output ready);
endinterface

// File: hw/rtl/tfdig_dof_if.sv
// Result channel: one face point index per item
interface tfdig_dof_if import tfdig_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] dof_index;
  logic             last_point;
  logic             bad_face;

  modport source (output valid, output dof_index, output last_point, output bad_face,
                  input ready);
  modport sink   (input valid, input dof_index, input last_point, input bad_face,
                  output ready);
endinterface

// File: hw/rtl/tfdig_regs.sv
// APB configuration registers: element dimension and polynomial order
module tfdig_regs import tfdig_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [DIM_W-1:0]   space_dim,
  output logic [ORDER_W-1:0] poly_order
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[PADDR_W-1];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      space_dim  <= DIM_RESET;
      poly_order <= ORDER_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SPACE_DIM:  space_dim  <= pwdata[DIM_W-1:0];
        REG_POLY_ORDER: poly_order <= pwdata[ORDER_W-1:0];
        default:        ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_sel)
      REG_SPACE_DIM:  prdata = PDATA_W'(space_dim);
      REG_POLY_ORDER: prdata = PDATA_W'(poly_order);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/tfdig_dpath.sv
// Datapath: face geometry, strides, offset and the mixed-radix point walk
module tfdig_dpath import tfdig_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER
) (
  input  logic               clk,
  input  logic [FACE_W-1:0]  face_number,
  input  logic [DIM_W-1:0]   space_dim,
  input  logic [ORDER_W-1:0] poly_order,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  output logic [IDX_W-1:0]   dof_index,
  output logic               bad_face
);

  localparam int DIG_W = $clog2(MAX_ORDER + 1);

  logic [FACE_W-1:0] face;
  logic [1:0]        normal;
  logic              level;
  logic [1:0]        nfa;
  logic [DIG_W-1:0]  ord;
  logic [IDX_W-1:0]  nn;
  logic [IDX_W-1:0]  s0;
  logic [IDX_W-1:0]  s1;
  logic [IDX_W-1:0]  base;
  logic [IDX_W-1:0]  idx;
  logic [DIG_W-1:0]  d0;
  logic [DIG_W-1:0]  d1;

  face_geom_t        geom;
  int unsigned       po_wide;
  logic [DIG_W-1:0]  ord_sat;
  logic [IDX_W-1:0]  n_cfg;
  logic [IDX_W-1:0]  n;
  logic [IDX_W-1:0]  stride_norm;
  logic [IDX_W-1:0]  offset;
  logic              d0_end;
  logic              d1_end;

  // order saturated to the largest supported one
  always_comb begin
    po_wide = int'(poly_order);
    ord_sat = (po_wide > MAX_ORDER) ? DIG_W'(MAX_ORDER) : DIG_W'(po_wide);
  end

  assign geom  = face_geom(space_dim, face);
  assign n_cfg = IDX_W'(ord_sat) + IDX_W'(1);
  assign n     = IDX_W'(ord) + IDX_W'(1);

  // stride of the normal axis and the face offset
  always_comb begin
    case (normal)
      AXIS_X:  stride_norm = IDX_W'(1);
      AXIS_Y:  stride_norm = n;
      default: stride_norm = nn;
    endcase
    offset = level ? IDX_W'((n - IDX_W'(1)) * stride_norm) : '0;
  end

  // end of each digit; digits beyond the face axes count as finished
  assign d0_end      = (nfa == 2'd0) || (d0 == ord);
  assign d1_end      = (nfa < 2'd2) || (d1 == ord);
  assign status.last = bad_face || (d0_end && d1_end);
  assign dof_index   = idx;

  always_ff @(posedge clk) begin
    // capture the face
    if (cmd.load) begin
      face <= face_number;
    end
    // decode the face and square the point count
    if (cmd.geom) begin
      bad_face <= geom.bad;
      normal   <= geom.normal;
      level    <= geom.level;
      nfa      <= geom.nfa;
      ord      <= ord_sat;
      nn       <= IDX_W'(n_cfg * n_cfg);
    end
    // strides of the face axes, first point
    if (cmd.init) begin
      case (normal)
        AXIS_X: begin
          s0 <= n;
          s1 <= nn;
        end
        AXIS_Y: begin
          s0 <= IDX_W'(1);
          s1 <= nn;
        end
        default: begin
          s0 <= IDX_W'(1);
          s1 <= n;
        end
      endcase
      base <= bad_face ? '0 : offset;
      idx  <= bad_face ? '0 : offset;
      d0   <= '0;
      d1   <= '0;
    end
    // next face point: first axis fastest
    if (cmd.step) begin
      if (!d0_end) begin
        d0  <= d0 + DIG_W'(1);
        idx <= idx + s0;
      end else begin
        d0   <= '0;
        d1   <= d1 + DIG_W'(1);
        base <= base + s1;
        idx  <= base + s1;
      end
    end
  end

endmodule

// File: hw/rtl/tfdig_ctrl.sv
// Controller: sequences one face request from capture to its last result
`include "tensor_face_dof_index_generator_defines.svh"
module tfdig_ctrl import tfdig_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       face_valid,
  output logic       face_ready,
  output logic       res_valid,
  input  logic       res_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_GEOM = 4'b0010,
    S_INIT = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    face_ready = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        face_ready = 1'b1;
        if (face_valid) begin
          cmd.load   = 1'b1;
          state_next = S_GEOM;
        end
      end
      S_GEOM: begin
        cmd.geom   = 1'b1;
        state_next = S_INIT;
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (status.last) begin
            state_next = S_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // one request in flight at a time
  `TFDIG_ASSERT_IMP(a_req_res_excl, clk, rst, face_ready, !res_valid)
  `TFDIG_ASSERT_NXT(a_accept_busy, clk, rst, face_valid && face_ready, !face_ready && !res_valid)
  `TFDIG_ASSERT_NXT(a_last_frees, clk, rst, res_valid && res_ready && status.last, face_ready)

endmodule

// File: hw/rtl/tensor_face_dof_index_generator.sv
// Top level of the tensor-product face index generator
//
// Usage:
//   Configure space_dim (byte address 0) and poly_order (byte address 4)
//   over the APB port while no request is in flight. Each item on face_req
//   names a face; dof_res then carries, one item per point, the volume-local
//   index of every point of that face, first face axis fastest, with
//   last_point set on the final one. A face number outside the range of the
//   dimension gives a single item with bad_face and last_point set.
// Timing:
//   The first result is valid once the face is decoded and then the offset
//   and strides are loaded (states S_GEOM, then S_INIT). Points then follow
//   one per cycle while dof_res is ready, from an incrementing index
//   accumulator. A new request is taken in the cycle after the last result
//   leaves.
// Reset: synchronous; dimension returns to 3, order to 1, controller idles.
// Stall: a held result keeps its value and the walk waits until taken.
module tensor_face_dof_index_generator import tfdig_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER
) (
  input  logic               clk,
  input  logic               rst,
  tfdig_face_if.sink         face_req,
  tfdig_dof_if.source        dof_res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [DIM_W-1:0]   space_dim;
  logic [ORDER_W-1:0] poly_order;
  dp_cmd_t            cmd;
  dp_status_t         status;

  // configuration registers
  tfdig_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .space_dim  (space_dim),
    .poly_order (poly_order)
  );

  // index datapath
  tfdig_dpath #(
    .MAX_ORDER (MAX_ORDER)
  ) u_dpath (
    .clk         (clk),
    .face_number (face_req.face_number),
    .space_dim   (space_dim),
    .poly_order  (poly_order),
    .cmd         (cmd),
    .status      (status),
    .dof_index   (dof_res.dof_index),
    .bad_face    (dof_res.bad_face)
  );

  // sequencing
  tfdig_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .face_valid (face_req.valid),
    .face_ready (face_req.ready),
    .res_valid  (dof_res.valid),
    .res_ready  (dof_res.ready),
    .status     (status),
    .cmd        (cmd)
  );

  assign dof_res.last_point = status.last;

endmodule

// File: tb/tb_tensor_face_dof_index_generator.sv
// Self-checking testbench for the tensor-product face index generator
`timescale 1ns / 100ps

module tb_tensor_face_dof_index_generator import tfdig_pkg::*;;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned MAX_REPORTS = 20;

  // one expected face point
  typedef struct packed {
    logic [IDX_W-1:0] dof_index;
    logic             last_point;
    logic             bad_face;
  } face_point_t;

  // Works out the points of each accepted face and checks the results in order
  class face_point_board;
    logic [DIM_W-1:0]   space_dim;
    logic [ORDER_W-1:0] poly_order;
    face_point_t        pending_points[$];
    int unsigned        mismatches;
    int unsigned        faces_seen;
    int unsigned        points_seen;
    int unsigned        bad_seen;

    function new();
      space_dim   = DIM_RESET;
      poly_order  = ORDER_RESET;
      mismatches  = 0;
      faces_seen  = 0;
      points_seen = 0;
      bad_seen    = 0;
    endfunction

    function int unsigned pending();
      return pending_points.size();
    endfunction

    task report(input string what);
      if (mismatches < MAX_REPORTS) begin
        $display("[%0t] mismatch: %s", $realtime, what);
      end
      mismatches++;
    endtask

    // expand one face request into its run of volume indices
    function void note_face(input logic [FACE_W-1:0] face);
      int unsigned n, normal_ax, base, nfa, count, j, idx;
      int unsigned ax_stride [3];
      int unsigned fa_stride [2];
      logic        lvl, ok;
      face_point_t p;
      faces_seen++;
      case (space_dim)
        2'd1: ok = (face < 3'd2);
        2'd2: ok = (face < 3'd4);
        2'd3: ok = (face < 3'd6);
        default: ok = 1'b0;
      endcase
      if (!ok) begin
        p.dof_index  = '0;
        p.last_point = 1'b1;
        p.bad_face   = 1'b1;
        pending_points.push_back(p);
        return;
      end
      // normal axis and level of the face
      normal_ax = AXIS_X;
      lvl       = 1'b0;
      if (space_dim == 2'd1) begin
        lvl = face[0];
      end else if (space_dim == 2'd2) begin
        normal_ax = (face == 3'd0 || face == 3'd2) ? AXIS_Y : AXIS_X;
        lvl       = (face == 3'd1 || face == 3'd2);
      end else begin
        case (face)
          3'd0: begin normal_ax = AXIS_Z; lvl = 1'b0; end
          3'd1: begin normal_ax = AXIS_Y; lvl = 1'b0; end
          3'd2: begin normal_ax = AXIS_X; lvl = 1'b1; end
          3'd3: begin normal_ax = AXIS_Y; lvl = 1'b1; end
          3'd4: begin normal_ax = AXIS_X; lvl = 1'b0; end
          default: begin normal_ax = AXIS_Z; lvl = 1'b1; end
        endcase
      end
      // order cannot exceed the saturation bound with a 3-bit register
      n            = int'(poly_order) + 1;
      ax_stride[0] = 1;
      ax_stride[1] = n;
      ax_stride[2] = n * n;
      base         = lvl ? (n - 1) * ax_stride[normal_ax] : 0;
      // face axes: the remaining ones, ascending
      nfa = 0;
      for (int a = 0; a < int'(space_dim); a++) begin
        if (a != int'(normal_ax)) begin
          fa_stride[nfa] = ax_stride[a];
          nfa++;
        end
      end
      count = 1;
      for (int k = 0; k < int'(nfa); k++) count = count * n;
      // mixed-radix walk, first face axis fastest
      for (int unsigned i = 0; i < count; i++) begin
        idx = base;
        j   = i;
        for (int k = 0; k < int'(nfa); k++) begin
          idx = idx + fa_stride[k] * (j % n);
          j   = j / n;
        end
        p.dof_index  = idx[IDX_W-1:0];
        p.last_point = (i == count - 1);
        p.bad_face   = 1'b0;
        pending_points.push_back(p);
      end
    endfunction

    task check_point(input logic [IDX_W-1:0] dof_index, input logic last_point,
                     input logic bad_face);
      face_point_t e;
      points_seen++;
      if (bad_face) bad_seen++;
      if (pending_points.size() == 0) begin
        report($sformatf("unexpected item idx=%0d last=%0b bad=%0b",
                         dof_index, last_point, bad_face));
      end else begin
        e = pending_points.pop_front();
        if (dof_index !== e.dof_index)
          report($sformatf("dof_index %0d, expected %0d", dof_index, e.dof_index));
        if (last_point !== e.last_point)
          report($sformatf("last_point %0b, expected %0b", last_point, e.last_point));
        if (bad_face !== e.bad_face)
          report($sformatf("bad_face %0b, expected %0b", bad_face, e.bad_face));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  tfdig_face_if face_req_if ();
  tfdig_dof_if  dof_res_if ();

  face_point_board face_board;
  bit              src_idle_on  = 1'b0;
  bit              sink_idle_on = 1'b0;
  bit              hold_req     = 1'b0;
  int unsigned     cycle_count  = 0;
  int unsigned     settings_run = 1;

  tensor_face_dof_index_generator u_top (
    .clk      (clk),
    .rst      (rst),
    .face_req (face_req_if),
    .dof_res  (dof_res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d points pending", cycle_count,
               face_board.pending());
      $display("TB_ERROR");
      $finish;
    end
  end

  // watch both channels; values seen here are the ones before the edge
  always @(posedge clk) begin
    if (!rst && face_req_if.valid && face_req_if.ready)
      face_board.note_face(face_req_if.face_number);
    if (!rst && dof_res_if.valid && dof_res_if.ready)
      face_board.check_point(dof_res_if.dof_index, dof_res_if.last_point,
                             dof_res_if.bad_face);
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned held;
    dof_res_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        dof_res_if.ready <= 1'b0;
        for (held = 0; held < LONG_HOLD; held++) @(posedge clk);
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        dof_res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      dof_res_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // register write: setup cycle, then access until pready
  task automatic apb_write(input logic reg_sel, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // stop offering and wait for every pending point to come back; the first
  // edge lets the monitor note a face taken at the edge we were called on
  task automatic drain();
    face_req_if.valid <= 1'b0;
    @(posedge clk);
    while (face_board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [DIM_W-1:0] dim, input logic [ORDER_W-1:0] ord);
    drain();
    apb_write(REG_SPACE_DIM, PDATA_W'(dim));
    apb_write(REG_POLY_ORDER, PDATA_W'(ord));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    face_board.space_dim  = dim;
    face_board.poly_order = ord;
    settings_run++;
  endtask

  // offer one face, with an optional gap first; valid stays up afterwards
  task automatic send_face(input logic [FACE_W-1:0] f);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      face_req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    face_req_if.valid       <= 1'b1;
    face_req_if.face_number <= f;
    do @(posedge clk); while (!face_req_if.ready);
  endtask

  task automatic send_range(input int unsigned lo, input int unsigned hi);
    for (int unsigned f = lo; f <= hi; f++) send_face(FACE_W'(f));
  endtask

  initial begin
    int unsigned        phase, k, lim;
    logic [DIM_W-1:0]   dim;
    logic [ORDER_W-1:0] ord;
    logic [FACE_W-1:0]  f;
    face_board              = new();
    rst                     = 1'b1;
    face_req_if.valid       = 1'b0;
    face_req_if.face_number = '0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset setting with every face number, then the corners
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    send_range(0, 7);
    set_config(2'd1, 3'd7);   // 1D at top order, two invalid faces
    send_range(0, 3);
    set_config(2'd2, 3'd0);   // 2D at order zero, one invalid face
    send_range(0, 4);
    set_config(2'd0, 3'd3);   // dimension zero: everything is a bad face
    send_range(6, 7);
    set_config(2'd3, 3'd7);   // largest faces
    send_range(0, 5);

    // random phases; the last one runs without any idling
    for (phase = 0; phase < 10; phase++) begin
      dim = ($urandom_range(0, 9) == 0) ? 2'd0 : DIM_W'($urandom_range(1, 3));
      ord = ($urandom_range(0, 3) == 0) ? ORDER_W'($urandom_range(4, 7))
                                        : ORDER_W'($urandom_range(0, 3));
      set_config(dim, ord);
      src_idle_on  = (phase < 9) && ($urandom_range(0, 2) != 0);
      sink_idle_on = (phase < 9) && ($urandom_range(0, 2) != 0);
      if (phase == 4) hold_req = 1'b1;
      lim = (dim == 2'd0) ? 7 : 2 * int'(dim) - 1;
      for (k = 0; k < 23; k++) begin
        f = ($urandom_range(0, 4) == 0) ? FACE_W'($urandom_range(0, 7))
                                        : FACE_W'($urandom_range(0, lim));
        send_face(f);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Ran %0d face requests over %0d register settings in %0d cycles.",
             face_board.faces_seen, settings_run, cycle_count);
    $display("Checked %0d face points, %0d of them bad-face, %0d mismatches.",
             face_board.points_seen, face_board.bad_seen, face_board.mismatches);
    if (face_board.mismatches == 0 && face_board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
